/* design/bounded_undo_redo_history_macros.svh */
// Assertion helpers shared by the history block.
`ifndef BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH
`define BOUNDED_UNDO_REDO_HISTORY_MACROS_SVH

// Same-cycle implication.
`define BURH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BURH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/burh_pkg.sv */
`default_nettype none
package burh_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int MAXU_W    = 7;
   localparam int SEQ_W     = 32;
   localparam int PAY_W     = 32;
   localparam int FUNC_W    = 2;
   localparam int DIR_W     = 2;

   localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNDO   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REDO   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UNDO = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REDO = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic exec;   // request accepted, update stacks this edge
      logic load;   // capture ring read data into the response
   } burh_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_load;  // pending request moves an entry out of the ring
   } burh_status_type;

endpackage
`default_nettype wire

/* design/burh_ctrl.sv */
`default_nettype none
`include "bounded_undo_redo_history_macros.svh"
module burh_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire burh_pkg::burh_status_type status,
   output burh_pkg::burh_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      cmd.load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = status.need_load ? ST_LOAD : ST_RESP;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BURH_ASSERT_SAME(a_one_side, clock, reset, 1'b1, !(req_ready && rsp_valid), "ready while result pending")

endmodule
`default_nettype wire

/* design/burh_dp.sv */
`default_nettype none
`include "bounded_undo_redo_history_macros.svh"
module burh_dp #(
   parameter int DEPTH = burh_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire burh_pkg::burh_cmd_type        cmd,
   output burh_pkg::burh_status_type          status,
   input  wire logic                          csr_we,
   input  wire logic [burh_pkg::MAXU_W-1:0]   csr_wdata,
   input  wire logic [burh_pkg::FUNC_W-1:0]   req_func,
   input  wire logic                          req_reversible,
   input  wire logic [burh_pkg::SEQ_W-1:0]    req_seq_in,
   input  wire logic [burh_pkg::PAY_W-1:0]    req_payload_in,
   output logic                               rsp_applied,
   output logic [burh_pkg::DIR_W-1:0]         rsp_direction,
   output logic [burh_pkg::SEQ_W-1:0]         rsp_seq_out,
   output logic [burh_pkg::PAY_W-1:0]         rsp_payload_out,
   output logic                               rsp_can_undo,
   output logic                               rsp_can_redo,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_undo_count,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_redo_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = CNT_W + 1;
   localparam int LIM_W = (CNT_W > burh_pkg::MAXU_W) ? CNT_W : burh_pkg::MAXU_W;
   localparam int ENT_W = burh_pkg::SEQ_W + burh_pkg::PAY_W;

   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
   localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

   // ring offset -> physical slot; sum is always below twice the depth
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] red;
      red = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
      return red[IDX_W-1:0];
   endfunction

   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;

   logic [burh_pkg::MAXU_W-1:0] max_undo_ff;
   logic [IDX_W-1:0]            base_ff, base_in;
   logic [CNT_W-1:0]            undo_ff, undo_in;
   logic [CNT_W-1:0]            redo_ff, redo_in;
   logic [burh_pkg::SEQ_W-1:0]  next_seq_ff, next_seq_in;
   logic                        applied_ff, applied_in;
   logic [burh_pkg::DIR_W-1:0]  dir_ff, dir_in;
   logic [burh_pkg::SEQ_W-1:0]  out_seq_ff, out_seq_in;
   logic [burh_pkg::PAY_W-1:0]  out_pay_ff, out_pay_in;

   logic [LIM_W-1:0]           maxu_ext;
   logic [CNT_W-1:0]           lim;
   logic [SUM_W-1:0]           undo_s, base_s, grow_s, excess_s;
   logic                       trim;
   logic [IDX_W-1:0]           base_trim, top_addr, below_addr, rd_addr;
   logic [CNT_W-1:0]           undo_trim;
   logic                       do_undo, do_redo, wr_en, rd_en;
   logic                       auto_seq;
   logic [burh_pkg::SEQ_W-1:0] rec_seq;

   // effective depth limit: zero or anything past the ring means full ring
   assign maxu_ext = LIM_W'(max_undo_ff);
   assign lim = (maxu_ext == '0 || maxu_ext > DEPTH_L) ? CNT_W'(DEPTH) : CNT_W'(maxu_ext);

   assign undo_s     = SUM_W'(undo_ff);
   assign base_s     = SUM_W'(base_ff);
   assign grow_s     = undo_s + SUM_W'(1);
   assign excess_s   = grow_s - SUM_W'(lim);
   assign trim       = grow_s > SUM_W'(lim);
   assign base_trim  = trim ? wrap_idx(base_s + excess_s) : base_ff;
   assign undo_trim  = trim ? lim : CNT_W'(grow_s);
   assign top_addr   = wrap_idx(base_s + undo_s);
   assign below_addr = wrap_idx(base_s + undo_s - SUM_W'(1));

   assign do_undo = (req_func == burh_pkg::FUNC_UNDO) && (undo_ff != '0);
   assign do_redo = (req_func == burh_pkg::FUNC_REDO) && (redo_ff != '0);
   assign status.need_load = do_undo || do_redo;

   assign auto_seq = (req_seq_in == '0);
   assign rec_seq  = auto_seq ? next_seq_ff : req_seq_in;
   assign rd_addr  = do_undo ? below_addr : top_addr;

   always_comb begin
      base_in     = base_ff;
      undo_in     = undo_ff;
      redo_in     = redo_ff;
      next_seq_in = next_seq_ff;
      applied_in  = applied_ff;
      dir_in      = dir_ff;
      out_seq_in  = out_seq_ff;
      out_pay_in  = out_pay_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      if (cmd.exec) begin
         applied_in = 1'b0;
         dir_in     = burh_pkg::DIR_NONE;
         out_seq_in = '0;
         out_pay_in = '0;
         unique case (req_func)
            burh_pkg::FUNC_RECORD: begin
               if (req_reversible) begin
                  wr_en      = 1'b1;
                  redo_in    = '0;
                  base_in    = base_trim;
                  undo_in    = undo_trim;
                  applied_in = 1'b1;
                  out_seq_in = rec_seq;
                  out_pay_in = req_payload_in;
                  if (auto_seq) begin
                     next_seq_in = next_seq_ff + 1'b1;
                  end else if (req_seq_in >= next_seq_ff) begin
                     next_seq_in = req_seq_in + 1'b1;
                  end
               end
            end
            burh_pkg::FUNC_UNDO: begin
               if (do_undo) begin
                  rd_en      = 1'b1;
                  undo_in    = undo_ff - 1'b1;
                  redo_in    = redo_ff + 1'b1;
                  applied_in = 1'b1;
                  dir_in     = burh_pkg::DIR_UNDO;
               end
            end
            burh_pkg::FUNC_REDO: begin
               if (do_redo) begin
                  rd_en      = 1'b1;
                  base_in    = base_trim;
                  undo_in    = undo_trim;
                  redo_in    = redo_ff - 1'b1;
                  applied_in = 1'b1;
                  dir_in     = burh_pkg::DIR_REDO;
               end
            end
            burh_pkg::FUNC_CLEAR: begin
               base_in     = '0;
               undo_in     = '0;
               redo_in     = '0;
               next_seq_in = burh_pkg::SEQ_W'(1);
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end else if (cmd.load) begin
         out_seq_in = rd_data_ff[ENT_W-1:burh_pkg::PAY_W];
         out_pay_in = rd_data_ff[burh_pkg::PAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[top_addr] <= {rec_seq, req_payload_in};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_undo_ff <= '0;
         base_ff     <= '0;
         undo_ff     <= '0;
         redo_ff     <= '0;
         next_seq_ff <= burh_pkg::SEQ_W'(1);
      end else begin
         if (csr_we) begin
            max_undo_ff <= csr_wdata;
         end
         base_ff     <= base_in;
         undo_ff     <= undo_in;
         redo_ff     <= redo_in;
         next_seq_ff <= next_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      applied_ff <= applied_in;
      dir_ff     <= dir_in;
      out_seq_ff <= out_seq_in;
      out_pay_ff <= out_pay_in;
   end

   assign rsp_applied     = applied_ff;
   assign rsp_direction   = dir_ff;
   assign rsp_seq_out     = out_seq_ff;
   assign rsp_payload_out = out_pay_ff;
   assign rsp_can_undo    = (undo_ff != '0);
   assign rsp_can_redo    = (redo_ff != '0);
   assign rsp_undo_count  = undo_ff;
   assign rsp_redo_count  = redo_ff;

   `BURH_ASSERT_SAME(a_ring_fill, clock, reset, 1'b1, (int'(undo_ff) + int'(redo_ff)) <= DEPTH, "stacks overflow ring")
   `BURH_ASSERT_NEXT(a_record_push, clock, reset, cmd.exec && wr_en, (undo_ff != '0) && (redo_ff == '0), "record left bad stacks")
   `BURH_ASSERT_NEXT(a_clear, clock, reset, cmd.exec && (req_func == burh_pkg::FUNC_CLEAR), (undo_ff == '0) && (redo_ff == '0) && (next_seq_ff == burh_pkg::SEQ_W'(1)), "clear incomplete")
   `BURH_ASSERT_SAME(a_load_applied, clock, reset, cmd.load, applied_ff && (dir_ff != burh_pkg::DIR_NONE), "load without a move")

endmodule
`default_nettype wire

/* design/bounded_undo_redo_history.sv */
`default_nettype none
// Bounded undo/redo history: an undo stack and a redo stack of commands
// (sequence number plus payload word) sharing one ring of DEPTH entries.
// Each request returns exactly one response. Record, clear and any refused
// or empty-stack request give a response the cycle after acceptance; undo
// and redo that move an entry pass a load state, for the registered read
// of the ring memory. One request is in flight at a time: req_ready rises
// again once the response has been taken. The undo depth limit (csr_wdata,
// 0 = full ring, values past DEPTH act as DEPTH) may only be written while
// the block is idle; a lowered limit takes effect on the next record or redo.
// Ring contents need no clearing after reset, so requests are taken at once.
module bounded_undo_redo_history #(
   parameter int DEPTH = burh_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_we,
   input  wire logic [burh_pkg::MAXU_W-1:0]   csr_wdata,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [burh_pkg::FUNC_W-1:0]   req_func,
   input  wire logic                          req_reversible,
   input  wire logic [burh_pkg::SEQ_W-1:0]    req_seq_in,
   input  wire logic [burh_pkg::PAY_W-1:0]    req_payload_in,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_applied,
   output logic [burh_pkg::DIR_W-1:0]         rsp_direction,
   output logic [burh_pkg::SEQ_W-1:0]         rsp_seq_out,
   output logic [burh_pkg::PAY_W-1:0]         rsp_payload_out,
   output logic                               rsp_can_undo,
   output logic                               rsp_can_redo,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_undo_count,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_redo_count
);

   // controller <-> datapath handshake
   burh_pkg::burh_cmd_type    cmd;
   burh_pkg::burh_status_type status;

   // sequencing: idle -> (optional ring read) -> response held until taken
   burh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ring memory, stack pointers, sequence counter and response registers
   burh_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_func        (req_func),
      .req_reversible  (req_reversible),
      .req_seq_in      (req_seq_in),
      .req_payload_in  (req_payload_in),
      .rsp_applied     (rsp_applied),
      .rsp_direction   (rsp_direction),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_can_undo    (rsp_can_undo),
      .rsp_can_redo    (rsp_can_redo),
      .rsp_undo_count  (rsp_undo_count),
      .rsp_redo_count  (rsp_redo_count)
   );

endmodule
`default_nettype wire

/* test/history_checker.sv */
`timescale 1ns / 1ps
module history_checker #(
   parameter int DEPTH = burh_pkg::DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [burh_pkg::MAXU_W-1:0]         csr_wdata,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic [burh_pkg::FUNC_W-1:0]         req_func,
   input  wire logic                                req_reversible,
   input  wire logic [burh_pkg::SEQ_W-1:0]          req_seq_in,
   input  wire logic [burh_pkg::PAY_W-1:0]          req_payload_in,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                rsp_applied,
   input  wire logic [burh_pkg::DIR_W-1:0]          rsp_direction,
   input  wire logic [burh_pkg::SEQ_W-1:0]          rsp_seq_out,
   input  wire logic [burh_pkg::PAY_W-1:0]          rsp_payload_out,
   input  wire logic                                rsp_can_undo,
   input  wire logic                                rsp_can_redo,
   input  wire logic [$clog2(DEPTH+1)-1:0]          rsp_undo_count,
   input  wire logic [$clog2(DEPTH+1)-1:0]          rsp_redo_count,
   output int                                       fail_count,
   output int                                       waiting_count,
   output int                                       checked_count
);
   import burh_pkg::*;

   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [PAY_W-1:0] payload;
   } command_type;

   typedef struct packed {
      logic             applied;
      logic [DIR_W-1:0] direction;
      logic [SEQ_W-1:0] seq;
      logic [PAY_W-1:0] payload;
      logic             can_undo;
      logic             can_redo;
      logic [CNT_W-1:0] undo_count;
      logic [CNT_W-1:0] redo_count;
   } outcome_type;

   // shadow copy of the history
   command_type       ring [DEPTH];
   int                ring_base;
   int                undo_n;
   int                redo_n;
   logic [SEQ_W-1:0]  next_seq;
   logic [MAXU_W-1:0] depth_cap;

   outcome_type history_outcomes [$];
   int          reported;

   initial begin
      fail_count    = 0;
      waiting_count = 0;
      checked_count = 0;
      reported      = 0;
   end

   function automatic int ring_slot(input int offset);
      return (ring_base + offset) % DEPTH;
   endfunction

   // drop oldest undo entries above the active limit
   function automatic void trim_oldest();
      int lim;
      lim = (depth_cap == '0 || depth_cap > DEPTH) ? DEPTH : int'(depth_cap);
      if (undo_n > lim) begin
         ring_base = ring_slot(undo_n - lim);
         undo_n    = lim;
      end
   endfunction

   function automatic outcome_type step_history(
      input logic [FUNC_W-1:0] func,
      input logic              reversible,
      input logic [SEQ_W-1:0]  seq,
      input logic [PAY_W-1:0]  payload
   );
      outcome_type o;
      command_type moved;
      o     = '0;
      moved = '0;
      case (func)
         FUNC_RECORD: begin
            if (reversible) begin
               redo_n = 0;
               if (seq == '0) begin
                  seq      = next_seq;
                  next_seq = next_seq + 1'b1;
               end else if (seq >= next_seq) begin
                  next_seq = seq + 1'b1;
               end
               moved.seq               = seq;
               moved.payload           = payload;
               ring[ring_slot(undo_n)] = moved;
               undo_n++;
               trim_oldest();
               o.applied = 1'b1;
            end
         end
         FUNC_UNDO: begin
            if (undo_n != 0) begin
               undo_n--;
               redo_n++;
               moved       = ring[ring_slot(undo_n)];
               o.applied   = 1'b1;
               o.direction = DIR_UNDO;
            end
         end
         FUNC_REDO: begin
            if (redo_n != 0) begin
               moved = ring[ring_slot(undo_n)];
               undo_n++;
               redo_n--;
               trim_oldest();
               o.applied   = 1'b1;
               o.direction = DIR_REDO;
            end
         end
         default: begin
            ring_base = 0;
            undo_n    = 0;
            redo_n    = 0;
            next_seq  = 1;
         end
      endcase
      o.seq        = moved.seq;
      o.payload    = moved.payload;
      o.can_undo   = (undo_n != 0);
      o.can_redo   = (redo_n != 0);
      o.undo_count = CNT_W'(undo_n);
      o.redo_count = CNT_W'(redo_n);
      return o;
   endfunction

   task automatic note_failure(input string what);
      fail_count = fail_count + 1;
      if (reported < REPORT_LIMIT) begin
         reported++;
         $display("[%0t] %s", $time, what);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got));
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         ring_base = 0;
         undo_n    = 0;
         redo_n    = 0;
         next_seq  = 1;
         depth_cap = '0;
         history_outcomes.delete();
      end else begin
         if (csr_we)
            depth_cap = csr_wdata;
         // response first: it belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (history_outcomes.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               want = history_outcomes.pop_front();
               check_field("applied", 32'(want.applied), 32'(rsp_applied));
               check_field("direction", 32'(want.direction), 32'(rsp_direction));
               check_field("seq_out", want.seq, rsp_seq_out);
               check_field("payload_out", want.payload, rsp_payload_out);
               check_field("can_undo", 32'(want.can_undo), 32'(rsp_can_undo));
               check_field("can_redo", 32'(want.can_redo), 32'(rsp_can_redo));
               check_field("undo_count", 32'(want.undo_count), 32'(rsp_undo_count));
               check_field("redo_count", 32'(want.redo_count), 32'(rsp_redo_count));
            end
         end
         if (req_valid && req_ready)
            history_outcomes.insert(history_outcomes.size(),
                                    step_history(req_func, req_reversible,
                                                 req_seq_in, req_payload_in));
      end
      waiting_count = history_outcomes.size();
   end

endmodule

/* test/tb_bounded_undo_redo_history.sv */
`timescale 1ns / 1ps
module tb_bounded_undo_redo_history;
   import burh_pkg::*;

   localparam int DEPTH        = DEPTH_DEF;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   // worst quiet stretch is a sender gap plus a long receiver stall plus
   // the ring read; this is far beyond that
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   // receiver back-pressure styles
   localparam int READY_ALWAYS     = 0;
   localparam int READY_COIN       = 1;
   localparam int READY_LONG_STALL = 2;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [MAXU_W-1:0]   csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func;
   logic                req_reversible;
   logic [SEQ_W-1:0]    req_seq_in;
   logic [PAY_W-1:0]    req_payload_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_applied;
   logic [DIR_W-1:0]    rsp_direction;
   logic [SEQ_W-1:0]    rsp_seq_out;
   logic [PAY_W-1:0]    rsp_payload_out;
   logic                rsp_can_undo;
   logic                rsp_can_redo;
   logic [CNT_W-1:0]    rsp_undo_count;
   logic [CNT_W-1:0]    rsp_redo_count;

   int fail_count;
   int waiting_count;
   int checked_count;

   int sent_by_func [4];
   int limits_written;
   int burst_left;
   int idle_cycles;

   int stall_mode;
   int mode_cycles_left;
   int stall_run;

   bounded_undo_redo_history #(.DEPTH(DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_reversible  (req_reversible),
      .req_seq_in      (req_seq_in),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_applied     (rsp_applied),
      .rsp_direction   (rsp_direction),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_can_undo    (rsp_can_undo),
      .rsp_can_redo    (rsp_can_redo),
      .rsp_undo_count  (rsp_undo_count),
      .rsp_redo_count  (rsp_redo_count)
   );

   history_checker #(.DEPTH(DEPTH)) u_history_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_reversible  (req_reversible),
      .req_seq_in      (req_seq_in),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_applied     (rsp_applied),
      .rsp_direction   (rsp_direction),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_can_undo    (rsp_can_undo),
      .rsp_can_redo    (rsp_can_redo),
      .rsp_undo_count  (rsp_undo_count),
      .rsp_redo_count  (rsp_redo_count),
      .fail_count      (fail_count),
      .waiting_count   (waiting_count),
      .checked_count   (checked_count)
   );

   // 20 ns clock, high then low
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side back-pressure. Each style holds for a random run, then a new one is drawn:
   // always ready, a coin toss per cycle, or ready between random stall
   // runs. Driven on the falling edge like every other input.
   always @(negedge clock) begin
      if (mode_cycles_left == 0) begin
         stall_mode       = $urandom_range(READY_LONG_STALL, READY_ALWAYS);
         mode_cycles_left = $urandom_range(120, 20);
      end else begin
         mode_cycles_left = mode_cycles_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= 1'($urandom_range(1, 0));
         end
         default: begin
            if (stall_run == 0) begin
               rsp_ready <= 1'b1;
               if ($urandom_range(3, 0) == 0)
                  stall_run = $urandom_range(20, 1);
            end else begin
               rsp_ready <= 1'b0;
               stall_run = stall_run - 1;
            end
         end
      endcase
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request on the falling edge and hold it until it is taken.
   // A back-to-back request simply re-drives valid high, so valid sees only
   // one assignment per step.
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic rev,
                               input logic [SEQ_W-1:0] seq,
                               input logic [PAY_W-1:0] payload);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_reversible <= rev;
      req_seq_in     <= seq;
      req_payload_in <= payload;
      sent_by_func[func]++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender bursts: 1..12 requests, then a random gap that may be empty. An
   // empty gap joins bursts into longer stretches with no idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
   endtask

   // Sequence numbers: nearly half automatic, some small (often below the
   // counter, so no raise), some full range, and some right at the top so
   // the counter keeps wrapping through zero.
   function automatic logic [SEQ_W-1:0] pick_seq();
      int r;
      r = $urandom_range(99, 0);
      if (r < 45)
         return '0;
      else if (r < 70)
         return $urandom;
      else if (r < 88)
         return $urandom_range(400, 1);
      else
         return 32'hFFFF_FFFF - $urandom_range(3, 0);
   endfunction

   function automatic logic [PAY_W-1:0] pick_payload();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // One random request. record_pct and clear_pct steer the stack depth:
   // record-heavy mixes fill the ring, the rest splits between undo and redo.
   task automatic random_request(input int record_pct, input int clear_pct);
      int                r;
      logic [FUNC_W-1:0] func;
      logic              rev;
      r = $urandom_range(99, 0);
      if (r < clear_pct)
         func = FUNC_CLEAR;
      else if (r < clear_pct + record_pct)
         func = FUNC_RECORD;
      else if (r < clear_pct + record_pct + (100 - clear_pct - record_pct) / 2)
         func = FUNC_UNDO;
      else
         func = FUNC_REDO;
      // about one record in ten is refused
      rev = (func == FUNC_RECORD) ? ($urandom_range(9, 0) != 0)
                                  : 1'($urandom_range(1, 0));
      pace_sender();
      send_request(func, rev, pick_seq(), pick_payload());
   endtask

   // Drain to idle, then load a new undo limit. The stacks are left as they
   // are, so a lowered limit leaves an excess for the next record or redo.
   task automatic load_undo_limit(input logic [MAXU_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      limits_written++;
      burst_left = 0;
   endtask

   task automatic run_phase(input logic [MAXU_W-1:0] limit, input int record_pct,
                            input int clear_pct, input int n_requests);
      load_undo_limit(limit);
      repeat (n_requests) random_request(record_pct, clear_pct);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_func         = FUNC_RECORD;
      req_reversible   = 1'b0;
      req_seq_in       = '0;
      req_payload_in   = '0;
      rsp_ready        = 1'b0;
      stall_mode       = READY_ALWAYS;
      mode_cycles_left = 0;
      stall_run        = 0;
      idle_cycles      = 0;
      limits_written   = 0;
      burst_left       = 0;
      foreach (sent_by_func[i]) sent_by_func[i] = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening, reset limit (full ring):
      // empty stacks, refused record, counter raise and no-raise,
      // undo/redo round trip, redo cleared by record, counter wrap, clear.
      send_request(FUNC_UNDO,   1'b1, 32'd7,         32'h1234_5678);
      send_request(FUNC_REDO,   1'b1, 32'd7,         32'h1234_5678);
      send_request(FUNC_RECORD, 1'b0, 32'd50,        32'hFFFF_FFFF);
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'h0000_0000);
      send_request(FUNC_RECORD, 1'b1, 32'd100,       32'hA5A5_0001);
      send_request(FUNC_RECORD, 1'b1, 32'd5,         32'h5A5A_0002);
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'hC3C3_0003);
      send_request(FUNC_UNDO,   1'b0, 32'd0,         32'd0);
      send_request(FUNC_UNDO,   1'b0, 32'd0,         32'd0);
      send_request(FUNC_REDO,   1'b0, 32'd0,         32'd0);
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'h3C3C_0004);
      send_request(FUNC_REDO,   1'b0, 32'd0,         32'd0);
      send_request(FUNC_RECORD, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'h0F0F_0005);   // numbered 0
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'hF0F0_0006);
      send_request(FUNC_UNDO,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_CLEAR,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_UNDO,   1'b0, 32'd0,         32'd0);
      send_request(FUNC_RECORD, 1'b1, 32'd0,         32'h8000_0001);

      // Random phases: limit, record %, clear %, requests.
      run_phase(7'd0,   60, 2, 40);
      run_phase(7'd1,   50, 3, 30);   // single-entry history
      run_phase(7'd64,  90, 0, 90);   // fill the ring and wrap its base
      run_phase(7'd5,   30, 0, 40);   // lowered with a large excess
      run_phase(7'd127, 85, 0, 80);   // past the ring depth
      run_phase(7'd2,   40, 3, 30);
      run_phase(7'd65,  60, 2, 40);
      run_phase(7'd33,  55, 2, 50);
      run_phase(7'd0,   50, 3, 50);

      @(negedge clock);
      req_valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d record, %0d undo, %0d redo, %0d clear), %0d responses checked",
               sent_by_func[FUNC_RECORD] + sent_by_func[FUNC_UNDO] +
               sent_by_func[FUNC_REDO] + sent_by_func[FUNC_CLEAR],
               sent_by_func[FUNC_RECORD], sent_by_func[FUNC_UNDO],
               sent_by_func[FUNC_REDO], sent_by_func[FUNC_CLEAR], checked_count);
      $display("Undo limit loaded %0d times: full ring, 1, 2, the ring depth and beyond; %0d failures",
               limits_written, fail_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/burh_pkg.sv
design/burh_ctrl.sv
design/burh_dp.sv
design/bounded_undo_redo_history.sv
test/history_checker.sv
test/tb_bounded_undo_redo_history.sv
